// ===== sv/positional_insert_erase_list_core_defines.svh =====
// Assertion macros for the positional insert/erase list core.
`ifndef POSITIONAL_INSERT_ERASE_LIST_CORE_DEFINES_SVH
`define POSITIONAL_INSERT_ERASE_LIST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock, masked while reset is asserted.
`define PIEL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("list core assertion failed");
// Check a property on every clock, reset included.
`define PIEL_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("list core assertion failed");
`else
`define PIEL_ASSERT(lbl, prop)
`define PIEL_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== sv/piel_pkg.sv =====
// Shared types and constants for the positional insert/erase list core.
package piel_pkg;

    localparam int FUNC_W    = 2;
    localparam int POS_W     = 6;
    localparam int DATA_W    = 32;
    localparam int CNT_OUT_W = 7;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND = 2'd0,
        FN_INSERT = 2'd1,
        FN_ERASE  = 2'd2,
        FN_READ   = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-transfer commands broadcast to every cell; writes are qualified by transfer and status, the read by status.
    typedef struct packed {
        logic wr_append;
        logic wr_insert;
        logic wr_erase;
        logic rd_en;
    } t_cell_ctrl;

endpackage

// ===== sv/piel_cell.sv =====
// One list entry: holds a word and shifts it with its neighbors on insert/erase.
module piel_cell
    import piel_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int WIDTH = 32,
    parameter int KW    = 7
) (
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [KW-1:0]    i_pos,
    input  logic [KW-1:0]    i_cnt,
    input  logic [WIDTH-1:0] i_din,
    input  logic [WIDTH-1:0] i_left,
    input  logic [WIDTH-1:0] i_right,
    output logic [WIDTH-1:0] o_val,
    output logic [WIDTH-1:0] o_rd
);

    localparam logic [KW-1:0] IDX = KW'(INDEX);

    logic [WIDTH-1:0] r_val;
    logic [WIDTH-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.wr_append && (IDX == i_cnt)) begin
            n_val = i_din;
        end
        if (i_ctrl.wr_insert) begin
            if (IDX == i_pos) begin
                n_val = i_din;
            end else if (IDX > i_pos) begin
                n_val = i_left;
            end
        end
        // pull the upper neighbor down from the erased slot onward
        if (i_ctrl.wr_erase && (IDX >= i_pos)) begin
            n_val = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_rd  = (i_ctrl.rd_en && (IDX == i_pos)) ? r_val : '0;

endmodule

// ===== sv/piel_rd_tree.sv =====
// Registered OR tree that gathers the selected cell word for a read.
module piel_rd_tree
    import piel_pkg::*;
#(
    parameter int N     = 64,
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic [WIDTH-1:0] i_rd [N],
    output logic [WIDTH-1:0] o_value
);

    localparam int GRP  = 8;
    localparam int NGRP = (N + GRP - 1) / GRP;

    logic [WIDTH-1:0] r_grp [NGRP];
    logic [WIDTH-1:0] n_grp [NGRP];

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < N) begin
                    n_grp[g] = n_grp[g] | i_rd[g * GRP + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int g = 0; g < NGRP; g++) begin
                r_grp[g] <= n_grp[g];
            end
        end
    end

    always_comb begin
        o_value = '0;
        for (int g = 0; g < NGRP; g++) begin
            o_value = o_value | r_grp[g];
        end
    end

endmodule

// ===== sv/positional_insert_erase_list_core.sv =====
// Positional insert/erase list: a row of entry cells with a registered read tree.
// The result is registered in the read tree stage and then in the output register;
// only one request is in flight, and the next transfer is taken as the current
// result leaves.
// Reset: synchronous, active low; clears the count and the valid flags, the entry
// words are left as they are.
`include "positional_insert_erase_list_core_defines.svh"

module positional_insert_erase_list_core
    import piel_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // position[5:0], data_in[37:6], zero pad [39:38]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]    s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // read_value[31:0], element_count[38:32], zero pad [39]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [STAT_W-1:0]    m_axis_tuser
);

    localparam int CW         = $clog2(DEPTH + 1);
    localparam int KW         = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
    localparam int READ_CELLS = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_st_v;
    t_status              r_st_status;
    logic [CNT_OUT_W-1:0] r_st_count;
    logic                 r_out_v;
    logic [DATA_W-1:0]    r_out_data;
    logic [CNT_OUT_W-1:0] r_out_count;
    t_status              r_out_status;

    logic                 w_in_xfer;
    logic                 w_out_xfer;
    t_func                w_func;
    logic [KW-1:0]        w_pos;
    logic [KW-1:0]        w_cnt;
    logic [KW-1:0]        w_cnt_next;
    logic                 w_full;
    t_status              w_status;
    t_cell_ctrl           w_ctrl;
    logic [63:0]          w_din_ext;
    logic [WIDTH-1:0]     w_din;
    logic [WIDTH-1:0]     w_val [DEPTH];
    logic [WIDTH-1:0]     w_rd [READ_CELLS];
    logic [WIDTH-1:0]     w_tree;
    logic [63:0]          w_tree_ext;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = !r_st_v && (!r_out_v || m_axis_tready);

    assign w_func    = t_func'(s_axis_tuser);
    assign w_pos     = KW'(s_axis_tdata[POS_W-1:0]);
    assign w_cnt     = KW'(r_count);
    assign w_full    = (r_count == CW'(DEPTH));
    assign w_din_ext = {32'b0, s_axis_tdata[POS_W +: DATA_W]};
    assign w_din     = w_din_ext[WIDTH-1:0];

    always_comb begin
        w_status = ST_OK;
        case (w_func)
            FN_APPEND: begin
                if (w_full) w_status = ST_FULL;
            end
            FN_INSERT: begin
                if (w_pos > w_cnt) w_status = ST_RANGE;
                else if (w_full) w_status = ST_FULL;
            end
            FN_ERASE, FN_READ: begin
                if (w_pos >= w_cnt) w_status = ST_RANGE;
            end
            default: w_status = ST_RANGE;
        endcase
    end

    always_comb begin
        w_ctrl.wr_append = w_in_xfer && (w_status == ST_OK) && (w_func == FN_APPEND);
        w_ctrl.wr_insert = w_in_xfer && (w_status == ST_OK) && (w_func == FN_INSERT);
        w_ctrl.wr_erase  = w_in_xfer && (w_status == ST_OK) && (w_func == FN_ERASE);
        w_ctrl.rd_en     = (w_status == ST_OK) && (w_func == FN_READ);
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.wr_append || w_ctrl.wr_insert) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.wr_erase) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_cnt_next = KW'(n_count);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] w_left;
        logic [WIDTH-1:0] w_right;
        assign w_left  = (g == 0) ? w_val[g] : w_val[(g == 0) ? 0 : g - 1];
        assign w_right = (g == DEPTH - 1) ? w_val[g] : w_val[(g == DEPTH - 1) ? g : g + 1];
        if (g < READ_CELLS) begin : g_rd
            piel_cell #(
                .INDEX (g),
                .WIDTH (WIDTH),
                .KW    (KW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_pos   (w_pos),
                .i_cnt   (w_cnt),
                .i_din   (w_din),
                .i_left  (w_left),
                .i_right (w_right),
                .o_val   (w_val[g]),
                .o_rd    (w_rd[g])
            );
        end else begin : g_nord
            piel_cell #(
                .INDEX (g),
                .WIDTH (WIDTH),
                .KW    (KW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_pos   (w_pos),
                .i_cnt   (w_cnt),
                .i_din   (w_din),
                .i_left  (w_left),
                .i_right (w_right),
                .o_val   (w_val[g]),
                .o_rd    ()
            );
        end
    end

    piel_rd_tree #(
        .N     (READ_CELLS),
        .WIDTH (WIDTH)
    ) u_rd_tree (
        .i_clk   (i_clk),
        .i_load  (w_in_xfer),
        .i_rd    (w_rd),
        .o_value (w_tree)
    );

    assign w_tree_ext = 64'(w_tree);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_st_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_count <= n_count;
            r_st_v  <= w_in_xfer;
            if (r_st_v) begin
                r_out_v <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload: status and count ride with the read tree stage
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_st_status <= w_status;
            r_st_count  <= w_cnt_next[CNT_OUT_W-1:0];
        end
        if (r_st_v) begin
            r_out_data   <= w_tree_ext[DATA_W-1:0];
            r_out_count  <= r_st_count;
            r_out_status <= r_st_status;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {1'b0, r_out_count, r_out_data};
    assign m_axis_tuser  = r_out_status;

    `PIEL_ASSERT(a_count_bound, r_count <= CW'(DEPTH))
    `PIEL_ASSERT(a_stage_drains, r_st_v |=> r_out_v)
    `PIEL_ASSERT(a_one_in_flight, !(r_st_v && r_out_v))
    `PIEL_ASSERT(a_read_zero_on_error,
        (r_out_v && (r_out_status != ST_OK)) |-> (r_out_data == '0))

endmodule
